// File: sv/apo_pkg.sv
// shared types and constants for the aabb point push-out block
package apo_pkg;

    localparam int MAX_BOXES = 16;
    localparam int AW        = $clog2(MAX_BOXES);
    localparam int CNTW      = $clog2(MAX_BOXES + 1);

    localparam int CW  = 16;
    localparam int HW  = 15;
    localparam int RW  = 12;
    localparam int LW  = 15;
    localparam int BCW = 5;
    localparam int PW  = 18;
    localparam int WW  = 20;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 15;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_EDGE_LIMIT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BOX_COUNT  = 2'd1;

    localparam logic [LW-1:0]  EDGE_LIMIT_RST = 15'd14080;
    localparam logic [BCW-1:0] BOX_COUNT_RST  = 5'd0;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cz;
        logic [HW-1:0]        hx;
        logic [HW-1:0]        hz;
    } t_box;

endpackage

// File: sv/apo_if.sv
// channel interfaces for item, result and register write transfers
interface apo_in_if;
    import apo_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [3:0]           box_index;
    logic signed [CW-1:0] box_centre_x;
    logic signed [CW-1:0] box_centre_z;
    logic [HW-1:0]        box_half_x;
    logic [HW-1:0]        box_half_z;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_z;
    logic [RW-1:0]        radius;

    modport source (
        output valid, command, box_index, box_centre_x, box_centre_z,
               box_half_x, box_half_z, point_x, point_z, radius,
        input  ready
    );
    modport sink (
        input  valid, command, box_index, box_centre_x, box_centre_z,
               box_half_x, box_half_z, point_x, point_z, radius,
        output ready
    );
endinterface

interface apo_out_if;
    import apo_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_z;

    modport source (output valid, out_x, out_z, input ready);
    modport sink (input valid, out_x, out_z, output ready);
endinterface

interface apo_cfg_if;
    import apo_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/apo_box_step.sv
// push-out of the running point against one widened box
module apo_box_step (
    input  logic signed [apo_pkg::PW-1:0] i_px,
    input  logic signed [apo_pkg::PW-1:0] i_pz,
    input  apo_pkg::t_box                 i_box,
    input  logic [apo_pkg::RW-1:0]        i_radius,
    output logic signed [apo_pkg::PW-1:0] o_px,
    output logic signed [apo_pkg::PW-1:0] o_pz
);
    import apo_pkg::*;

    logic signed [WW-1:0] px_w, pz_w, cx_w, cz_w, hx, hz;
    logic signed [WW-1:0] dx, dz, ax, az, gx, gz, fx, fz;
    logic                 hit;

    assign px_w = $signed({{(WW-PW){i_px[PW-1]}}, i_px});
    assign pz_w = $signed({{(WW-PW){i_pz[PW-1]}}, i_pz});
    assign cx_w = $signed({{(WW-CW){i_box.cx[CW-1]}}, i_box.cx});
    assign cz_w = $signed({{(WW-CW){i_box.cz[CW-1]}}, i_box.cz});
    assign hx   = $signed({{(WW-HW){1'b0}}, i_box.hx})
                + $signed({{(WW-RW){1'b0}}, i_radius});
    assign hz   = $signed({{(WW-HW){1'b0}}, i_box.hz})
                + $signed({{(WW-RW){1'b0}}, i_radius});

    assign dx = px_w - cx_w;
    assign dz = pz_w - cz_w;
    assign ax = dx[WW-1] ? -dx : dx;
    assign az = dz[WW-1] ? -dz : dz;
    assign gx = hx - ax;
    assign gz = hz - az;
    assign fx = dx[WW-1] ? cx_w - hx : cx_w + hx;
    assign fz = dz[WW-1] ? cz_w - hz : cz_w + hz;

    assign hit = (ax < hx) && (az < hz);

    always_comb begin
        o_px = i_px;
        o_pz = i_pz;
        if (hit) begin
            if (gx < gz) begin
                o_px = fx[PW-1:0];
            end else begin
                o_pz = fz[PW-1:0];
            end
        end
    end
endmodule

// File: sv/aabb_point_push_out_top.sv
// top level: box store, query sequencer, clamp and result register
// a load transfer writes the box store in its accept cycle, no result
// a query visits one box per cycle, then the clamp step writes the result register
// a new item is accepted only in idle, once the previous query has written its result; box_count saturated at MAX_BOXES
// the clamp cycle holds while the output register is full and not taken
// synchronous active-low reset clears control and configuration registers, datapath and box store are not cleared
module aabb_point_push_out_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    apo_in_if.sink            i_in,
    apo_out_if.source         o_out,
    apo_cfg_if.sink           i_cfg
);
    import apo_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_CLAMP = 2'd2;

    t_box                 mem [MAX_BOXES];
    t_box                 r_rd_data;
    logic [AW-1:0]        rd_addr;

    logic [1:0]           r_state, n_state;
    logic [AW-1:0]        r_idx, n_idx;
    logic [CNTW-1:0]      r_cnt, n_cnt;
    logic signed [PW-1:0] r_px, n_px, r_pz, n_pz;
    logic [RW-1:0]        r_radius, n_radius;
    logic [LW-1:0]        r_edge_limit;
    logic [BCW-1:0]       r_box_count;
    logic                 r_out_valid, n_out_valid;
    logic signed [CW-1:0] r_out_x, n_out_x, r_out_z, n_out_z;

    logic                 in_xfer, load_xfer, query_xfer, out_free, last;
    logic [CNTW-1:0]      sat_cnt;
    logic signed [PW-1:0] step_px, step_pz;
    logic signed [PW-1:0] lim_p, lim_n;

    assign in_xfer    = i_in.valid && i_in.ready;
    assign load_xfer  = in_xfer && (i_in.command == CMD_LOAD);
    assign query_xfer = in_xfer && (i_in.command == CMD_QUERY);
    assign out_free   = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid = r_out_valid;
    assign o_out.out_x = r_out_x;
    assign o_out.out_z = r_out_z;

    assign sat_cnt = (r_box_count > BCW'(MAX_BOXES)) ? CNTW'(MAX_BOXES)
                                                     : CNTW'(r_box_count);
    assign last    = ({1'b0, r_idx} == CNTW'(r_cnt - CNTW'(1)));
    assign rd_addr = (r_state == S_IDLE) ? '0 : AW'(r_idx + AW'(1));

    // box store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (load_xfer) begin
            mem[i_in.box_index[AW-1:0]] <= '{cx: i_in.box_centre_x,
                                            cz: i_in.box_centre_z,
                                            hx: i_in.box_half_x,
                                            hz: i_in.box_half_z};
        end
        r_rd_data <= mem[rd_addr];
    end

    apo_box_step u_step (
        .i_px     (r_px),
        .i_pz     (r_pz),
        .i_box    (r_rd_data),
        .i_radius (r_radius),
        .o_px     (step_px),
        .o_pz     (step_pz)
    );

    assign lim_p = $signed({{(PW-LW){1'b0}}, r_edge_limit});
    assign lim_n = -lim_p;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_px        = r_px;
        n_pz        = r_pz;
        n_radius    = r_radius;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_x     = r_out_x;
        n_out_z     = r_out_z;
        case (r_state)
            S_IDLE: begin
                if (query_xfer) begin
                    n_px     = $signed({{(PW-CW){i_in.point_x[CW-1]}}, i_in.point_x});
                    n_pz     = $signed({{(PW-CW){i_in.point_z[CW-1]}}, i_in.point_z});
                    n_radius = i_in.radius;
                    n_idx    = '0;
                    n_cnt    = sat_cnt;
                    n_state  = (sat_cnt == '0) ? S_CLAMP : S_RUN;
                end
            end
            S_RUN: begin
                n_px  = step_px;
                n_pz  = step_pz;
                n_idx = AW'(r_idx + AW'(1));
                if (last) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_px > lim_p) begin
                        n_out_x = lim_p[CW-1:0];
                    end else if (r_px < lim_n) begin
                        n_out_x = lim_n[CW-1:0];
                    end else begin
                        n_out_x = r_px[CW-1:0];
                    end
                    if (r_pz > lim_p) begin
                        n_out_z = lim_p[CW-1:0];
                    end else if (r_pz < lim_n) begin
                        n_out_z = lim_n[CW-1:0];
                    end else begin
                        n_out_z = r_pz[CW-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_edge_limit <= EDGE_LIMIT_RST;
            r_box_count  <= BOX_COUNT_RST;
            r_idx        <= '0;
            r_cnt        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_EDGE_LIMIT: r_edge_limit <= i_cfg.data[LW-1:0];
                    CFG_BOX_COUNT:  r_box_count  <= i_cfg.data[BCW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px     <= n_px;
        r_pz     <= n_pz;
        r_radius <= n_radius;
        r_out_x  <= n_out_x;
        r_out_z  <= n_out_z;
    end
endmodule

// File: tb/sv/apo_push_out_checker.sv
// checker for the aabb point push-out block: watches all channels, predicts and compares results
`timescale 1ns / 1ps

module apo_push_out_checker
    import apo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    apo_in_if    i_in,
    apo_out_if   i_out,
    apo_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] z;
    } t_point;

    t_box           box_mem [MAX_BOXES];
    logic [LW-1:0]  edge_limit;
    logic [BCW-1:0] box_count;
    t_point         resolved_q [$];
    int             fails;

    function automatic t_point resolve_point(input logic signed [CW-1:0] qx,
                                             input logic signed [CW-1:0] qz,
                                             input logic [RW-1:0]        qr);
        t_point res;
        int     px, pz, rad, lim, n, i;
        int     hx, hz, dx, dz, ax, az;
        px  = qx;
        pz  = qz;
        rad = qr;
        lim = edge_limit;
        n   = (box_count > MAX_BOXES) ? MAX_BOXES : box_count;
        for (i = 0; i < n; i++) begin
            hx = box_mem[i].hx;
            hz = box_mem[i].hz;
            hx = hx + rad;
            hz = hz + rad;
            dx = px - box_mem[i].cx;
            dz = pz - box_mem[i].cz;
            ax = (dx < 0) ? -dx : dx;
            az = (dz < 0) ? -dz : dz;
            // strictly inside the widened box, push along the smaller overlap, ties to z
            if (ax < hx && az < hz) begin
                if (hx - ax < hz - az) begin
                    px = box_mem[i].cx + ((dx < 0) ? -hx : hx);
                end else begin
                    pz = box_mem[i].cz + ((dz < 0) ? -hz : hz);
                end
            end
        end
        if (px > lim) px = lim;
        else if (px < -lim) px = -lim;
        if (pz > lim) pz = lim;
        else if (pz < -lim) pz = -lim;
        res.x = px[CW-1:0];
        res.z = pz[CW-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            edge_limit = EDGE_LIMIT_RST;
            box_count  = BOX_COUNT_RST;
            resolved_q.delete();
            fails      = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (resolved_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result transfer, expected none, actual x=%0d z=%0d",
                             $time, i_out.out_x, i_out.out_z);
                end else begin
                    want = resolved_q.pop_front();
                    if (i_out.out_x !== want.x) begin
                        fails++;
                        $display("%0t: out_x mismatch, expected %0d, actual %0d",
                                 $time, want.x, i_out.out_x);
                    end
                    if (i_out.out_z !== want.z) begin
                        fails++;
                        $display("%0t: out_z mismatch, expected %0d, actual %0d",
                                 $time, want.z, i_out.out_z);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.command == CMD_LOAD) begin
                    box_mem[i_in.box_index].cx = i_in.box_centre_x;
                    box_mem[i_in.box_index].cz = i_in.box_centre_z;
                    box_mem[i_in.box_index].hx = i_in.box_half_x;
                    box_mem[i_in.box_index].hz = i_in.box_half_z;
                end else begin
                    resolved_q = {resolved_q, resolve_point(i_in.point_x, i_in.point_z,
                                                            i_in.radius)};
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_EDGE_LIMIT: edge_limit = i_cfg.data[LW-1:0];
                    CFG_BOX_COUNT:  box_count  = i_cfg.data[BCW-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= resolved_q.size();
    end

endmodule

// File: tb/sv/tb_aabb_point_push_out_top.sv
// testbench top for the aabb point push-out block: stimulus, idling and final verdict
`timescale 1ns / 1ps

module tb_aabb_point_push_out_top;
    import apo_pkg::*;

    localparam int                DRAIN_CYCLES    = 40;
    localparam int                ITEMS_PER_PHASE = 230;
    localparam int                NUM_PHASES      = 8;
    localparam logic [CFG_IW-1:0] CFG_SPARE_2     = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_SPARE_3     = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic no_idle;
    int   stall_left;
    int   hold;
    int   act_boxes;
    int   sh_cx [MAX_BOXES];
    int   sh_cz [MAX_BOXES];
    int   sh_hx [MAX_BOXES];
    int   sh_hz [MAX_BOXES];

    apo_in_if  in_ch ();
    apo_out_if out_ch ();
    apo_cfg_if cfg_ch ();

    aabb_point_push_out_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    apo_push_out_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (no_idle) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            hold = pick_gap();
            if (hold == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                stall_left   <= hold - 1;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [3:0] slot,
                             input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cz,
                             input logic [HW-1:0] hx, input logic [HW-1:0] hz,
                             input logic signed [CW-1:0] px, input logic signed [CW-1:0] pz,
                             input logic [RW-1:0] rad, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.box_index    <= slot;
        in_ch.box_centre_x <= cx;
        in_ch.box_centre_z <= cz;
        in_ch.box_half_x   <= hx;
        in_ch.box_half_z   <= hz;
        in_ch.point_x      <= px;
        in_ch.point_z      <= pz;
        in_ch.radius       <= rad;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic load_box(input logic [3:0] slot,
                            input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cz,
                            input logic [HW-1:0] hx, input logic [HW-1:0] hz);
        sh_cx[slot] = cx;
        sh_cz[slot] = cz;
        sh_hx[slot] = hx;
        sh_hz[slot] = hz;
        send_item(CMD_LOAD, slot, cx, cz, hx, hz, CW'($urandom), CW'($urandom),
                  RW'($urandom), pick_gap());
    endtask

    task automatic query_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] pz,
                               input logic [RW-1:0] rad);
        send_item(CMD_QUERY, 4'($urandom), CW'($urandom), CW'($urandom), HW'($urandom),
                  HW'($urandom), px, pz, rad, pick_gap());
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(negedge i_clk); while (!cfg_ch.ready);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [LW-1:0] lim, input logic [BCW-1:0] cnt);
        logic [CFG_DW-1:0] word;
        write_reg(CFG_EDGE_LIMIT, lim);
        word          = CFG_DW'($urandom);
        word[BCW-1:0] = cnt;
        write_reg(CFG_BOX_COUNT, word);
        act_boxes = (cnt > MAX_BOXES) ? MAX_BOXES : cnt;
    endtask

    // wait until every query has its result and the block has gone quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [3:0]           slot;
        logic signed [CW-1:0] cx, cz, px, pz;
        logic [HW-1:0]        hx, hz;
        logic [RW-1:0]        rad;
        int                   sel, j, spx, spz;
        slot = 4'($urandom);
        cx   = CW'($urandom);
        cz   = CW'($urandom);
        hx   = HW'($urandom);
        hz   = HW'($urandom);
        px   = CW'($urandom);
        pz   = CW'($urandom);
        rad  = RW'($urandom);
        sel  = $urandom_range(0, 99);
        if (sel < 25) begin
            if (sel < 21) begin
                if (act_boxes > 0) slot = 4'($urandom_range(0, act_boxes - 1));
                cx = CW'(int'($urandom_range(0, 16384)) - 8192);
                cz = CW'(int'($urandom_range(0, 16384)) - 8192);
                hx = (sel < 3) ? '0 : HW'($urandom_range(0, 2047));
                hz = (sel == 1) ? '0 : HW'($urandom_range(0, 2047));
            end
            load_box(slot, cx, cz, hx, hz);
        end else begin
            if ($urandom_range(0, 9) < 7) rad = RW'($urandom_range(0, 768));
            if (sel < 90 && act_boxes > 0) begin
                j   = $urandom_range(0, act_boxes - 1);
                spx = sh_hx[j] + rad;
                spz = sh_hz[j] + rad;
                if (sel < 84) begin
                    px = CW'(sh_cx[j] + int'($urandom_range(0, 2 * spx + 128)) - spx - 64);
                    pz = CW'(sh_cz[j] + int'($urandom_range(0, 2 * spz + 128)) - spz - 64);
                end else begin
                    // exactly on a widened face
                    px = CW'(sh_cx[j] + (sel[0] ? spx : -spx));
                    pz = CW'(sh_cz[j] + int'($urandom_range(0, 2 * spz)) - spz);
                end
            end
            query_point(px, pz, rad);
        end
    endtask

    initial begin
        int             ph, k;
        logic [LW-1:0]  lim;
        logic [BCW-1:0] cnt;
        i_rst_n            <= 1'b0;
        no_idle            <= 1'b0;
        act_boxes           = 0;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= CMD_LOAD;
        in_ch.box_index    <= '0;
        in_ch.box_centre_x <= '0;
        in_ch.box_centre_z <= '0;
        in_ch.box_half_x   <= '0;
        in_ch.box_half_z   <= '0;
        in_ch.point_x      <= '0;
        in_ch.point_z      <= '0;
        in_ch.radius       <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_EDGE_LIMIT;
        cfg_ch.data        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every slot, extremes first, zero half-size in slot one
        load_box(0, 0, 0, 256, 512);
        load_box(1, 2560, 2560, 0, 0);
        load_box(2, -32768, 32767, 32767, 32767);
        load_box(3, 32767, -32768, 0, 32767);
        load_box(4, -32768, -32768, 32767, 0);
        for (k = 5; k < MAX_BOXES; k++) begin
            load_box(4'(k), CW'(int'($urandom_range(0, 16384)) - 8192),
                     CW'(int'($urandom_range(0, 16384)) - 8192),
                     HW'($urandom_range(1, 2047)), HW'($urandom_range(1, 2047)));
        end
        // reset settings: no boxes visited, default clamp
        query_point(32767, -32768, 4095);
        settle();

        // count above the store size saturates
        set_limits(15'h7FFF, 5'd31);
        query_point(0, 0, 0);
        query_point(0, 256, 0);
        query_point(256, 0, 0);
        query_point(2560, 2560, 0);
        query_point(2560, 2560, 4095);
        query_point(32767, 32767, 4095);
        query_point(-32768, -32768, 0);
        query_point(-32768, 32767, 4095);
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin lim = 15'h7FFF;          cnt = 5'd16; end
                1: begin lim = LW'($urandom);     cnt = 5'd31; end
                2: begin lim = EDGE_LIMIT_RST;    cnt = 5'd1;  end
                3: begin lim = LW'($urandom);     cnt = 5'd17; end
                4: begin lim = '0;                cnt = 5'd0;  end
                5: begin lim = LW'($urandom);     cnt = BCW'($urandom_range(2, 15)); end
                6: begin lim = 15'h7FFF;          cnt = 5'd8;  end
                default: begin lim = LW'($urandom_range(2048, 32767)); cnt = 5'd16; end
            endcase
            set_limits(lim, cnt);
            if (ph == 2 || ph == 5) begin
                write_reg(CFG_SPARE_2, CFG_DW'($urandom));
                write_reg(CFG_SPARE_3, CFG_DW'($urandom));
            end
            no_idle <= (ph == 3 || ph == 6);
            repeat (ITEMS_PER_PHASE) random_item();
            settle();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
